### rtl/core/radix2_fft_magnitude_top_defines.svh
// Assertion macros for the checker of the radix-2 FFT block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef RADIX2_FFT_MAGNITUDE_TOP_DEFINES_SVH
`define RADIX2_FFT_MAGNITUDE_TOP_DEFINES_SVH

// property holds in the same cycle as its trigger
`define R2FM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the cycle after its trigger
`define R2FM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/r2fm_pkg.sv
// Package for the radix-2 FFT magnitude block: sizes, state type, twiddle ROM.
// Depends on nothing.
package r2fm_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int TW_BITS      = 16;
    localparam int CW           = TW_BITS + 2;
    localparam int QUARTER      = MAX_POINTS / 4;
    localparam int QW           = $clog2(QUARTER) + 1;
    localparam int ROM_W        = TW_BITS + 1;
    localparam int LG_W         = 4;
    localparam int CNT_W        = ADDR_W + 1;
    localparam int BF_W         = ADDR_W - 1;
    localparam int PROD_W       = 32 + CW;
    localparam int ACC_W        = PROD_W + 1;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [1:0] REG_LOG2_LENGTH    = 2'd0;
    localparam logic [1:0] REG_MAGNITUDE_MODE = 2'd1;
    localparam logic       OP_LOAD            = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BF_A,
        S_BF_B,
        S_BF_M1,
        S_BF_M2,
        S_BF_WA,
        S_BF_WB,
        S_RD_WAIT,
        S_SQ_IM,
        S_SQRT,
        S_OUT
    } state_t;

    typedef logic [ROM_W-1:0] cos_rom_t [0:QUARTER];

    // quarter-wave cosine, Taylor series in Q30, rounded to Q(TW_BITS-1)
    // series divisors are (2i-1)*2i for terms one to ten
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint c;
        for (int j = 0; j <= QUARTER; j++) begin
            x    = (PI_Q30 * longint'(j)) / (2 * QUARTER);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            term = ((term * x2) >> 30) / 64'd2;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd12;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd30;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd56;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd90;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd132;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd182;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd240;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd306;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd380;
            sum  = sum + longint'(term);
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 << 30))
                sum = 64'sd1 << 30;
            c = (sum + (64'sd1 << (30 - TW_BITS))) >>> (31 - TW_BITS);
            rom[j] = c[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++)
            r[b] = v[ADDR_W-1-b];
        return r;
    endfunction

endpackage

### rtl/core/r2fm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module r2fm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/radix2_fft_magnitude_top.sv
// Radix-2 DIT FFT over a frame held in one RAM, with bin readout and magnitude.
// Depends on r2fm_pkg and r2fm_ram.
//
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_stall    operation, sample_*, bin_index
//  out       from block out_valid / out_stall  out_index .. in_range
//  cfg       to block   cfg_write              cfg_index, cfg_data
//
// A load writes its sample straight to its bit-reversed address in the RAM.
// The last load of a frame runs N/2*log2(N) butterflies, their steps set by the
// single RAM port pair (two reads, two writes per butterfly).
// A read runs a RAM read, two squares and 32 root steps; a refused one skips them.
// Reset clears control only; the RAM needs no clearing.
// in_stall is high while a transform or a read is in progress.
module radix2_fft_magnitude_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [r2fm_pkg::LG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic signed [15:0]              sample_real,
    input  logic signed [15:0]              sample_imag,
    input  logic [9:0]                      bin_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [9:0]                      out_index,
    output logic signed [31:0]              out_real,
    output logic signed [31:0]              out_imag,
    output logic [31:0]                     out_magnitude,
    output logic                            frame_ready,
    output logic                            in_range
);

    localparam int AW = r2fm_pkg::ADDR_W;

    r2fm_pkg::state_t state_reg, state_next;

    logic [r2fm_pkg::LG_W-1:0]  log2_reg;
    logic                       mode_reg;
    logic [r2fm_pkg::CNT_W-1:0] load_count_reg;
    logic                       done_reg;
    logic [r2fm_pkg::LG_W-1:0]  stage_reg;
    logic [r2fm_pkg::BF_W-1:0]  bf_reg;

    logic signed [r2fm_pkg::CW-1:0]    c_reg, s_reg;
    logic signed [31:0]                a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [31:0]                d_re_reg, d_im_reg;
    logic signed [r2fm_pkg::ACC_W-1:0] pr_reg, pi_reg;

    logic [9:0]         res_index_reg;
    logic signed [31:0] res_real_reg, res_imag_reg;
    logic               res_ready_reg, res_ok_reg;
    logic [63:0]        sum_reg, sq_val_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [4:0]         sq_cnt_reg;

    logic               out_valid_reg;
    logic [9:0]         out_index_reg;
    logic signed [31:0] out_real_reg, out_imag_reg;
    logic [31:0]        out_mag_reg;
    logic               out_ready_reg, out_ok_reg;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    r2fm_ram #(
        .WIDTH (64),
        .DEPTH (r2fm_pkg::MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective length
    logic [r2fm_pkg::LG_W-1:0]  lg;
    logic [r2fm_pkg::CNT_W-1:0] n_pts;
    logic [AW-1:0]              n_half;
    always_comb
    begin
        if (log2_reg == '0)
            lg = r2fm_pkg::LG_W'(1);
        else if (log2_reg > r2fm_pkg::LG_W'(AW))
            lg = r2fm_pkg::LG_W'(AW);
        else
            lg = log2_reg;
        n_pts  = r2fm_pkg::CNT_W'(1) << lg;
        n_half = AW'(1) << (lg - 1'b1);
    end

    logic in_acc, out_free, is_load, bin_ok, bf_last, stage_last;
    logic [r2fm_pkg::CNT_W-1:0] load_count_inc;
    logic [AW-1:0] load_addr;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign is_load  = (operation == r2fm_pkg::OP_LOAD);
    assign bin_ok   = mode_reg ? ({1'b0, bin_index} <= n_pts[AW:1])
                               : ({1'b0, bin_index} < n_pts);
    assign load_count_inc = load_count_reg + 1'b1;
    assign load_addr = r2fm_pkg::bit_rev(load_count_reg[AW-1:0])
                       >> (r2fm_pkg::LG_W'(AW) - lg);

    // butterfly addressing
    logic [AW-1:0] half, bf_ext, k_idx, a_addr, b_addr, m_wide;
    logic [r2fm_pkg::QW-1:0] m_idx;
    always_comb
    begin
        half   = AW'(1) << (stage_reg - 1'b1);
        bf_ext = {1'b0, bf_reg};
        k_idx  = bf_ext & (half - 1'b1);
        a_addr = ((bf_ext & ~(half - 1'b1)) << 1) | k_idx;
        b_addr = a_addr | half;
        m_wide = k_idx << (r2fm_pkg::LG_W'(AW) - stage_reg);
        m_idx  = m_wide[r2fm_pkg::QW-1:0];
    end
    assign bf_last    = (bf_ext == n_half - 1'b1);
    assign stage_last = (stage_reg == lg);

    // twiddle from the quarter-wave table
    logic signed [r2fm_pkg::CW-1:0] c_next, s_next;
    always_comb
    begin
        if (m_idx == '0)
        begin
            c_next = r2fm_pkg::CW'(r2fm_pkg::COS_ROM[0]);
            s_next = '0;
        end
        else if (m_idx <= r2fm_pkg::QW'(r2fm_pkg::QUARTER))
        begin
            c_next = r2fm_pkg::CW'(r2fm_pkg::COS_ROM[m_idx]);
            s_next = r2fm_pkg::CW'(r2fm_pkg::COS_ROM[r2fm_pkg::QW'(r2fm_pkg::QUARTER) - m_idx]);
        end
        else
        begin
            c_next = -r2fm_pkg::CW'(
                r2fm_pkg::COS_ROM[r2fm_pkg::QW'(2 * r2fm_pkg::QUARTER) - m_idx]);
            s_next = r2fm_pkg::CW'(r2fm_pkg::COS_ROM[m_idx - r2fm_pkg::QW'(r2fm_pkg::QUARTER)]);
        end
    end

    // two shared multipliers: b*c in M1, b*s in M2
    logic signed [31:0]                 mx0, mx1;
    logic signed [r2fm_pkg::CW-1:0]     my;
    logic signed [r2fm_pkg::PROD_W-1:0] mp0, mp1;
    always_comb
    begin
        if (state_reg == r2fm_pkg::S_BF_M1)
        begin
            mx0 = $signed(ram_rdata[63:32]);
            mx1 = $signed(ram_rdata[31:0]);
            my  = c_reg;
        end
        else
        begin
            mx0 = b_im_reg;
            mx1 = b_re_reg;
            my  = s_reg;
        end
        mp0 = mx0 * my;
        mp1 = mx1 * my;
    end

    logic signed [r2fm_pkg::ACC_W-1:0] pr_rnd, pi_rnd;
    logic signed [31:0] tr, ti;
    assign pr_rnd = pr_reg + r2fm_pkg::ACC_W'(1 << (r2fm_pkg::TW_BITS - 2));
    assign pi_rnd = pi_reg + r2fm_pkg::ACC_W'(1 << (r2fm_pkg::TW_BITS - 2));
    assign tr = pr_rnd[r2fm_pkg::TW_BITS+30:r2fm_pkg::TW_BITS-1];
    assign ti = pi_rnd[r2fm_pkg::TW_BITS+30:r2fm_pkg::TW_BITS-1];

    // squaring and root step
    logic [31:0] abs_rd, abs_im, sq_op;
    logic [63:0] sq;
    logic [35:0] rem_sh, trial;
    logic [33:0] rem_next;
    logic [31:0] root_next;
    always_comb
    begin
        abs_rd = ram_rdata[63] ? 32'(-$signed(ram_rdata[63:32])) : ram_rdata[63:32];
        abs_im = res_imag_reg[31] ? 32'(-res_imag_reg) : 32'(res_imag_reg);
        sq_op  = (state_reg == r2fm_pkg::S_SQ_IM) ? abs_im : abs_rd;
        sq     = sq_op * sq_op;
        rem_sh = {rem_reg, sq_val_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = 34'(rem_sh - trial);
            root_next = {root_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[33:0];
            root_next = {root_reg[30:0], 1'b0};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            r2fm_pkg::S_IDLE:
                if (in_acc)
                begin
                    if (is_load)
                    begin
                        if (load_count_inc >= n_pts)
                            state_next = r2fm_pkg::S_BF_A;
                    end
                    else if (done_reg && bin_ok)
                        state_next = r2fm_pkg::S_RD_WAIT;
                    else
                        state_next = r2fm_pkg::S_OUT;
                end
            r2fm_pkg::S_BF_A:    state_next = r2fm_pkg::S_BF_B;
            r2fm_pkg::S_BF_B:    state_next = r2fm_pkg::S_BF_M1;
            r2fm_pkg::S_BF_M1:   state_next = r2fm_pkg::S_BF_M2;
            r2fm_pkg::S_BF_M2:   state_next = r2fm_pkg::S_BF_WA;
            r2fm_pkg::S_BF_WA:   state_next = r2fm_pkg::S_BF_WB;
            r2fm_pkg::S_BF_WB:
                state_next = (bf_last && stage_last) ? r2fm_pkg::S_IDLE : r2fm_pkg::S_BF_A;
            r2fm_pkg::S_RD_WAIT: state_next = r2fm_pkg::S_SQ_IM;
            r2fm_pkg::S_SQ_IM:   state_next = r2fm_pkg::S_SQRT;
            r2fm_pkg::S_SQRT:
                if (sq_cnt_reg == 5'd31)
                    state_next = r2fm_pkg::S_OUT;
            r2fm_pkg::S_OUT:
                if (out_free)
                    state_next = r2fm_pkg::S_IDLE;
            default:             state_next = r2fm_pkg::S_IDLE;
        endcase
    end

    // RAM control and handshake outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = a_addr;
        ram_wdata = {tr + a_re_reg, ti + a_im_reg};
        ram_raddr = a_addr;
        in_stall  = (state_reg != r2fm_pkg::S_IDLE);
        case (state_reg)
            r2fm_pkg::S_IDLE:
            begin
                ram_raddr = bin_index;
                ram_waddr = load_addr;
                ram_wdata = {32'(sample_real),
                             mode_reg ? 32'd0 : 32'(sample_imag)};
                ram_we    = in_acc && is_load;
            end
            r2fm_pkg::S_BF_B:  ram_raddr = b_addr;
            r2fm_pkg::S_BF_WA: ram_we    = 1'b1;
            r2fm_pkg::S_BF_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = b_addr;
                ram_wdata = {d_re_reg, d_im_reg};
            end
            default: ram_we = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= r2fm_pkg::S_IDLE;
            log2_reg       <= r2fm_pkg::LG_W'(10);
            mode_reg       <= 1'b1;
            load_count_reg <= '0;
            done_reg       <= 1'b0;
            stage_reg      <= r2fm_pkg::LG_W'(1);
            bf_reg         <= '0;
            sq_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (cfg_index == r2fm_pkg::REG_LOG2_LENGTH ||
                              cfg_index == r2fm_pkg::REG_MAGNITUDE_MODE))
            begin
                if (cfg_index == r2fm_pkg::REG_LOG2_LENGTH)
                    log2_reg <= cfg_data;
                else
                    mode_reg <= cfg_data[0];
                load_count_reg <= '0;
                done_reg       <= 1'b0;
            end
            else if (state_reg == r2fm_pkg::S_IDLE && in_acc && is_load)
            begin
                done_reg <= 1'b0;
                if (load_count_inc >= n_pts)
                begin
                    load_count_reg <= '0;
                    stage_reg      <= r2fm_pkg::LG_W'(1);
                    bf_reg         <= '0;
                end
                else
                    load_count_reg <= load_count_inc;
            end
            if (state_reg == r2fm_pkg::S_BF_WB)
            begin
                if (bf_last)
                begin
                    bf_reg <= '0;
                    if (stage_last)
                        done_reg <= 1'b1;
                    else
                        stage_reg <= stage_reg + 1'b1;
                end
                else
                    bf_reg <= bf_reg + 1'b1;
            end
            if (state_reg == r2fm_pkg::S_SQRT)
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            else
                sq_cnt_reg <= '0;
            if (state_reg == r2fm_pkg::S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            r2fm_pkg::S_IDLE:
            begin
                res_index_reg <= bin_index;
                res_ready_reg <= done_reg;
                res_ok_reg    <= bin_ok;
                res_real_reg  <= '0;
                res_imag_reg  <= '0;
                root_reg      <= '0;
            end
            r2fm_pkg::S_BF_A:
            begin
                c_reg <= c_next;
                s_reg <= s_next;
            end
            r2fm_pkg::S_BF_B:
            begin
                a_re_reg <= $signed(ram_rdata[63:32]);
                a_im_reg <= $signed(ram_rdata[31:0]);
            end
            r2fm_pkg::S_BF_M1:
            begin
                b_re_reg <= $signed(ram_rdata[63:32]);
                b_im_reg <= $signed(ram_rdata[31:0]);
                pr_reg   <= r2fm_pkg::ACC_W'(mp0);
                pi_reg   <= r2fm_pkg::ACC_W'(mp1);
            end
            r2fm_pkg::S_BF_M2:
            begin
                // pr = br*c + bi*s, pi = bi*c - br*s
                pr_reg <= pr_reg + r2fm_pkg::ACC_W'(mp0);
                pi_reg <= pi_reg - r2fm_pkg::ACC_W'(mp1);
            end
            r2fm_pkg::S_BF_WA:
            begin
                d_re_reg <= a_re_reg - tr;
                d_im_reg <= a_im_reg - ti;
            end
            r2fm_pkg::S_RD_WAIT:
            begin
                // re squared straight from the RAM word
                res_real_reg <= $signed(ram_rdata[63:32]);
                res_imag_reg <= $signed(ram_rdata[31:0]);
                sum_reg      <= sq;
            end
            r2fm_pkg::S_SQ_IM:
            begin
                sq_val_reg <= sum_reg + sq;
                rem_reg    <= '0;
            end
            r2fm_pkg::S_SQRT:
            begin
                rem_reg    <= rem_next;
                root_reg   <= root_next;
                sq_val_reg <= {sq_val_reg[61:0], 2'b00};
            end
            default: ;
        endcase
        if (state_reg == r2fm_pkg::S_OUT && out_free)
        begin
            out_index_reg <= res_index_reg;
            out_real_reg  <= res_real_reg;
            out_imag_reg  <= res_imag_reg;
            out_mag_reg   <= root_reg;
            out_ready_reg <= res_ready_reg;
            out_ok_reg    <= res_ok_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_index     = out_index_reg;
    assign out_real      = out_real_reg;
    assign out_imag      = out_imag_reg;
    assign out_magnitude = out_mag_reg;
    assign frame_ready   = out_ready_reg;
    assign in_range      = out_ok_reg;

endmodule

### rtl/core/r2fm_checker.sv
// Port-level checks on the radix-2 FFT magnitude block, bound to the top level.
// Depends on radix2_fft_magnitude_top_defines.svh and radix2_fft_magnitude_top.
`include "radix2_fft_magnitude_top_defines.svh"

module r2fm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_real,
    input logic signed [31:0] out_imag,
    input logic [31:0]        out_magnitude,
    input logic               frame_ready,
    input logic               in_range
);

    logic [31:0] abs_real;
    assign abs_real = out_real[31] ? 32'(-out_real) : 32'(out_real);

    `R2FM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_real) && $stable(out_magnitude), "stalled item changed")
    `R2FM_ASSERT_SAME(a_not_ready_zero, out_valid && !frame_ready, out_real == 0 && out_imag == 0 && out_magnitude == 0, "item before frame not zero")
    `R2FM_ASSERT_SAME(a_range_zero, out_valid && !in_range, out_real == 0 && out_imag == 0 && out_magnitude == 0, "out of range item not zero")
    `R2FM_ASSERT_SAME(a_real_mag, out_valid && frame_ready && in_range && out_imag == 0, out_magnitude == abs_real, "magnitude of real bin wrong")

endmodule

bind radix2_fft_magnitude_top r2fm_checker u_r2fm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_real      (out_real),
    .out_imag      (out_imag),
    .out_magnitude (out_magnitude),
    .frame_ready   (frame_ready),
    .in_range      (in_range)
);
